/* sv/clma_pkg.sv */
package clma_pkg;

  localparam int unsigned CounterW    = 63;
  localparam int unsigned WideW       = 64;
  localparam int unsigned NumCounters = 9;
  localparam int unsigned IdleIndex   = 3;
  localparam int unsigned LoadW       = 7;
  localparam int unsigned LoadMaxInt  = 100;
  localparam logic [LoadW-1:0] LoadMax = LoadW'(LoadMaxInt);
  localparam int unsigned WindowLen   = 5;

  // Column sum of the bit-serial adders: carry plus one bit per counter.
  localparam int unsigned CarryW  = $clog2(NumCounters);
  localparam int unsigned ColW    = CarryW + 1;
  localparam int unsigned BitCntW = $clog2(WideW);

  // Restoring division of 100*a by b, one quotient bit per cycle.
  localparam int unsigned DivW     = WideW + LoadW;
  localparam int unsigned DvsShift = LoadW - 1;
  localparam int unsigned StepW    = $clog2(LoadW);

  // Window sum and mean by reciprocal multiplication.
  localparam int unsigned SumW      = $clog2(WindowLen * LoadMaxInt + 1);
  localparam int unsigned SeenW     = $clog2(WindowLen + 1);
  localparam int unsigned MeanShift = 16;
  localparam int unsigned RecipW    = MeanShift + 1;
  localparam int unsigned MeanRecip = ((1 << MeanShift) + WindowLen - 1) / WindowLen;
  localparam int unsigned ProdW     = SumW + RecipW;

  typedef struct packed {
    logic                sample_ok;
    logic [CounterW-1:0] user_time;
    logic [CounterW-1:0] nice_time;
    logic [CounterW-1:0] system_time;
    logic [CounterW-1:0] idle_time;
    logic [CounterW-1:0] iowait_time;
    logic [CounterW-1:0] irq_time;
    logic [CounterW-1:0] softirq_time;
    logic [CounterW-1:0] steal_time;
    logic [CounterW-1:0] guest_time;
  } clma_in_t;

  typedef struct packed {
    logic [LoadW-1:0] load_percent;
    logic             window_full;
  } clma_out_t;

  typedef struct packed {
    logic load;
    logic shift;
  } clma_ser_ctrl_t;

  // Deltas against the previous valid sample and their two's complement negations.
  typedef struct packed {
    logic [WideW-1:0] dbusy;
    logic [WideW-1:0] nbusy;
    logic [WideW-1:0] dtotal;
    logic [WideW-1:0] ntotal;
  } clma_delta_t;

endpackage

/* sv/clma_serial.sv */
module clma_serial
  import clma_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  clma_ser_ctrl_t ctrl_i,
  input  clma_in_t       sample_i,
  output clma_delta_t    delta_o
);

  logic [CounterW-1:0] ctr_in [NumCounters];
  logic [CounterW-1:0] cnt_q  [NumCounters];

  logic [CarryW-1:0] tot_c_q, tot_c_d, busy_c_q, busy_c_d;
  logic              tot_b_q, tot_b_d, busy_b_q, busy_b_d;
  logic              tot_s_q, tot_s_d, busy_s_q, busy_s_d;
  logic [WideW-1:0]  prev_busy_q, prev_total_q;
  logic [WideW-1:0]  dbusy_q, nbusy_q, dtotal_q, ntotal_q;

  logic [ColW-1:0] tot_sum, busy_sum;
  logic            tot_bit, busy_bit;
  logic            dbusy_bit, dtotal_bit, nbusy_bit, ntotal_bit;

  assign ctr_in[0] = sample_i.user_time;
  assign ctr_in[1] = sample_i.nice_time;
  assign ctr_in[2] = sample_i.system_time;
  assign ctr_in[3] = sample_i.idle_time;
  assign ctr_in[4] = sample_i.iowait_time;
  assign ctr_in[5] = sample_i.irq_time;
  assign ctr_in[6] = sample_i.softirq_time;
  assign ctr_in[7] = sample_i.steal_time;
  assign ctr_in[8] = sample_i.guest_time;

  // One column of the nine-way sum per cycle; busy leaves out the idle counter.
  always_comb begin
    tot_sum  = ColW'(tot_c_q);
    busy_sum = ColW'(busy_c_q);
    for (int i = 0; i < NumCounters; i++) begin
      tot_sum = tot_sum + ColW'(cnt_q[i][0]);
      if (i != IdleIndex) begin
        busy_sum = busy_sum + ColW'(cnt_q[i][0]);
      end
    end
    tot_bit  = tot_sum[0];
    busy_bit = busy_sum[0];
    tot_c_d  = tot_sum[ColW-1:1];
    busy_c_d = busy_sum[ColW-1:1];

    dbusy_bit  = busy_bit ^ prev_busy_q[0] ^ busy_b_q;
    busy_b_d   = (~busy_bit & (prev_busy_q[0] | busy_b_q)) | (prev_busy_q[0] & busy_b_q);
    dtotal_bit = tot_bit ^ prev_total_q[0] ^ tot_b_q;
    tot_b_d    = (~tot_bit & (prev_total_q[0] | tot_b_q)) | (prev_total_q[0] & tot_b_q);

    // Negation LSB first: bits pass unchanged up to and including the first one.
    nbusy_bit  = dbusy_bit ^ busy_s_q;
    busy_s_d   = busy_s_q | dbusy_bit;
    ntotal_bit = dtotal_bit ^ tot_s_q;
    tot_s_d    = tot_s_q | dtotal_bit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_c_q      <= '0;
      busy_c_q     <= '0;
      tot_b_q      <= 1'b0;
      busy_b_q     <= 1'b0;
      tot_s_q      <= 1'b0;
      busy_s_q     <= 1'b0;
      prev_busy_q  <= '0;
      prev_total_q <= '0;
    end else if (ctrl_i.load) begin
      tot_c_q  <= '0;
      busy_c_q <= '0;
      tot_b_q  <= 1'b0;
      busy_b_q <= 1'b0;
      tot_s_q  <= 1'b0;
      busy_s_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      tot_c_q      <= tot_c_d;
      busy_c_q     <= busy_c_d;
      tot_b_q      <= tot_b_d;
      busy_b_q     <= busy_b_d;
      tot_s_q      <= tot_s_d;
      busy_s_q     <= busy_s_d;
      prev_busy_q  <= {busy_bit, prev_busy_q[WideW-1:1]};
      prev_total_q <= {tot_bit, prev_total_q[WideW-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int i = 0; i < NumCounters; i++) begin
        cnt_q[i] <= ctr_in[i];
      end
    end else if (ctrl_i.shift) begin
      for (int i = 0; i < NumCounters; i++) begin
        cnt_q[i] <= cnt_q[i] >> 1;
      end
      dbusy_q  <= {dbusy_bit, dbusy_q[WideW-1:1]};
      nbusy_q  <= {nbusy_bit, nbusy_q[WideW-1:1]};
      dtotal_q <= {dtotal_bit, dtotal_q[WideW-1:1]};
      ntotal_q <= {ntotal_bit, ntotal_q[WideW-1:1]};
    end
  end

  assign delta_o.dbusy  = dbusy_q;
  assign delta_o.nbusy  = nbusy_q;
  assign delta_o.dtotal = dtotal_q;
  assign delta_o.ntotal = ntotal_q;

endmodule

/* sv/clma_ratio.sv */
module clma_ratio
  import clma_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  clma_delta_t      delta_i,
  output logic             done_o,
  output logic [LoadW-1:0] load_o
);

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhClass = 2'd1;
  localparam logic [1:0] PhMul   = 2'd2;
  localparam logic [1:0] PhDiv   = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic [DivW-1:0]  rem_q, rem_d, dvs_q, dvs_d;
  logic [LoadW-1:0] quot_q, quot_d, load_q, load_d;
  logic [StepW-1:0] step_q, step_d;
  logic             early_q, early_d;

  logic             neg_b, neg_t, zero_b, zero_t, hi_nz;
  logic [WideW-1:0] a_mag, b_mag;
  logic [DivW:0]    diff;
  logic             qbit;

  always_comb begin
    neg_b  = delta_i.dbusy[WideW-1];
    neg_t  = delta_i.dtotal[WideW-1];
    zero_b = (delta_i.dbusy == '0);
    zero_t = (delta_i.dtotal == '0);
    hi_nz  = |delta_i.dbusy[WideW-1:LoadW];
    a_mag  = neg_b ? delta_i.nbusy : delta_i.dbusy;
    b_mag  = neg_t ? delta_i.ntotal : delta_i.dtotal;
    diff   = {1'b0, rem_q} - {1'b0, dvs_q};
    qbit   = ~diff[DivW];

    phase_d = phase_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quot_d  = quot_q;
    load_d  = load_q;
    step_d  = step_q;
    early_d = early_q;
    done_o  = 1'b0;

    unique case (phase_q)
      PhIdle: begin
        if (start_i) begin
          rem_d   = DivW'(a_mag);
          dvs_d   = DivW'(b_mag) << DvsShift;
          early_d = zero_t | zero_b | (neg_b != neg_t);
          quot_d  = '0;
          // With an unchanged total a non-negative busy delta, clamped to LoadMax, is the load.
          if (zero_t && !neg_b) begin
            quot_d = (hi_nz || (delta_i.dbusy[LoadW-1:0] > LoadMax)) ?
                     LoadMax : delta_i.dbusy[LoadW-1:0];
          end
          phase_d = PhClass;
        end
      end
      PhClass: begin
        if (early_q) begin
          load_d  = quot_q;
          done_o  = 1'b1;
          phase_d = PhIdle;
        end else if (rem_q[WideW-1:0] >= dvs_q[DvsShift +: WideW]) begin
          load_d  = LoadMax;
          done_o  = 1'b1;
          phase_d = PhIdle;
        end else begin
          rem_d   = (rem_q << 2) + rem_q;
          phase_d = PhMul;
        end
      end
      PhMul: begin
        rem_d   = ((rem_q << 2) + rem_q) << 2;
        quot_d  = '0;
        step_d  = '0;
        phase_d = PhDiv;
      end
      PhDiv: begin
        if (qbit) begin
          rem_d = diff[DivW-1:0];
        end
        dvs_d  = dvs_q >> 1;
        quot_d = {quot_q[LoadW-2:0], qbit};
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(LoadW - 1)) begin
          load_d  = quot_d;
          done_o  = 1'b1;
          phase_d = PhIdle;
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      load_q  <= '0;
      step_q  <= '0;
      early_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      load_q  <= load_d;
      step_q  <= step_d;
      early_q <= early_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign load_o = load_q;

endmodule

/* sv/clma_window.sv */
module clma_window
  import clma_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [LoadW-1:0] load_i,
  output logic [LoadW-1:0] mean_o,
  output logic             full_o
);

  logic [LoadW-1:0] win_q [WindowLen];
  logic [SumW-1:0]  sum_q;
  logic [SeenW-1:0] seen_q;
  logic [SumW:0]    sum_ext;
  logic [ProdW-1:0] prod;

  // The running sum trades the oldest load for the newest one.
  assign sum_ext = {1'b0, sum_q} + (SumW + 1)'(load_i) - (SumW + 1)'(win_q[WindowLen-1]);
  assign prod    = ProdW'(sum_q) * ProdW'(MeanRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WindowLen; i++) begin
        win_q[i] <= '0;
      end
      sum_q  <= '0;
      seen_q <= '0;
    end else if (push_i) begin
      win_q[0] <= load_i;
      for (int i = 1; i < WindowLen; i++) begin
        win_q[i] <= win_q[i-1];
      end
      sum_q <= sum_ext[SumW-1:0];
      if (!full_o) begin
        seen_q <= seen_q + SeenW'(1);
      end
    end
  end

  assign full_o = (seen_q == SeenW'(WindowLen));
  assign mean_o = prod[MeanShift +: LoadW];

endmodule

/* sv/cpu_load_moving_average.sv */
// Flow: a valid sample passes through the bit-serial steps over all bits, a start step,
// then classify, scale and one-bit-per-cycle division, then push and mean. A load settled
// without division skips the scale and division steps; an invalid sample goes to push.
// One sample is in work at a time, so a new input is accepted only after the last result
// has entered the output register, which waits while that register is stalled.
// Reset clears the previous busy and total counts, the latest load and the load window.
module cpu_load_moving_average
  import clma_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  clma_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output clma_out_t out_data_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSerial = 3'd1;
  localparam logic [2:0] StStart  = 3'd2;
  localparam logic [2:0] StWait   = 3'd3;
  localparam logic [2:0] StPush   = 3'd4;
  localparam logic [2:0] StMean   = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic               out_valid_q, out_valid_d;
  clma_out_t          out_q, out_d;

  clma_ser_ctrl_t   ser_ctrl;
  clma_delta_t      delta;
  logic             ratio_start, ratio_done;
  logic [LoadW-1:0] latest_load, mean;
  logic             push, win_full;

  clma_serial u_serial (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ser_ctrl),
    .sample_i (in_data_i),
    .delta_o  (delta)
  );

  clma_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ratio_start),
    .delta_i (delta),
    .done_o  (ratio_done),
    .load_o  (latest_load)
  );

  clma_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .load_i (latest_load),
    .mean_o (mean),
    .full_o (win_full)
  );

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d        = state_q;
    bit_cnt_d      = bit_cnt_q;
    ser_ctrl.load  = 1'b0;
    ser_ctrl.shift = 1'b0;
    ratio_start    = 1'b0;
    push           = 1'b0;
    out_valid_d    = out_valid_q & ~out_ready_i;
    out_d          = out_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_data_i.sample_ok) begin
            ser_ctrl.load = 1'b1;
            bit_cnt_d     = '0;
            state_d       = StSerial;
          end else begin
            state_d = StPush;
          end
        end
      end
      StSerial: begin
        ser_ctrl.shift = 1'b1;
        bit_cnt_d      = bit_cnt_q + BitCntW'(1);
        if (bit_cnt_q == BitCntW'(WideW - 1)) begin
          state_d = StStart;
        end
      end
      StStart: begin
        ratio_start = 1'b1;
        state_d     = StWait;
      end
      StWait: begin
        if (ratio_done) begin
          state_d = StPush;
        end
      end
      StPush: begin
        push    = 1'b1;
        state_d = StMean;
      end
      StMean: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.window_full  = win_full;
          out_d.load_percent = win_full ? mean : '0;
          state_d            = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_load_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.load_percent <= LoadMax))
    else $error("load percent above the maximum");

  a_valid_to_serial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.sample_ok) |=> (state_q == StSerial))
    else $error("valid sample did not start the serial pass");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ratio_done |-> (state_q == StWait))
    else $error("load unit finished outside the wait state");

  a_full_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_full |=> win_full)
    else $error("window full flag dropped");

  a_empty_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.window_full) |-> (out_data_o.load_percent == '0))
    else $error("nonzero load before the window filled");
`endif

endmodule

/* tb/tb_cpu_load_moving_average.sv */
module tb_cpu_load_moving_average
  import clma_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfPeriod = 5;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainTail  = 100;
  localparam int unsigned PhaseItems = 285;
  localparam int unsigned MaxReports = 10;

  // Expected-result store with its own copy of the averaging state.
  class load_scoreboard;
    logic [WideW-1:0] prev_busy;
    logic [WideW-1:0] prev_total;
    logic [LoadW-1:0] last_load;
    logic [LoadW-1:0] ring [WindowLen];
    int unsigned      slot;
    int unsigned      seen;
    clma_out_t        expected_q [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      invalid_cnt;
    int unsigned      flat_cnt;
    int unsigned      full_load_cnt;

    function new();
      prev_busy     = '0;
      prev_total    = '0;
      last_load     = '0;
      foreach (ring[i]) ring[i] = '0;
      slot          = 0;
      seen          = 0;
      errors        = 0;
      checked       = 0;
      invalid_cnt   = 0;
      flat_cnt      = 0;
      full_load_cnt = 0;
    endfunction

    // Deltas are read as signed 64-bit values; the ratio is formed on 71 bits so that
    // 100 times the busy magnitude never overflows.
    function logic [LoadW-1:0] load_from_deltas(logic [WideW-1:0] dbusy,
                                                logic [WideW-1:0] dtotal);
      logic [WideW-1:0] mag_busy;
      logic [WideW-1:0] mag_total;
      logic [DivW-1:0]  ratio;
      if (dtotal == '0) begin
        if (dbusy[WideW-1]) return '0;
        return (dbusy > WideW'(LoadMaxInt)) ? LoadW'(LoadMaxInt) : dbusy[LoadW-1:0];
      end
      if (dbusy == '0 || dbusy[WideW-1] != dtotal[WideW-1]) return '0;
      mag_busy  = dbusy[WideW-1] ? -dbusy : dbusy;
      mag_total = dtotal[WideW-1] ? -dtotal : dtotal;
      if (mag_busy >= mag_total) return LoadW'(LoadMaxInt);
      ratio = (DivW'(mag_busy) * DivW'(LoadMaxInt)) / DivW'(mag_total);
      return ratio[LoadW-1:0];
    endfunction

    function void note_sample(clma_in_t s);
      logic [WideW-1:0] total;
      logic [WideW-1:0] busy;
      int unsigned      sum;
      clma_out_t        want;
      if (s.sample_ok) begin
        total = WideW'(s.user_time) + WideW'(s.nice_time) + WideW'(s.system_time)
              + WideW'(s.idle_time) + WideW'(s.iowait_time) + WideW'(s.irq_time)
              + WideW'(s.softirq_time) + WideW'(s.steal_time) + WideW'(s.guest_time);
        busy  = total - WideW'(s.idle_time);
        if (total == prev_total) flat_cnt++;
        last_load  = load_from_deltas(busy - prev_busy, total - prev_total);
        prev_busy  = busy;
        prev_total = total;
        if (last_load == LoadW'(LoadMaxInt)) full_load_cnt++;
      end else begin
        invalid_cnt++;
      end
      // The kept load is pushed even for an invalid sample.
      ring[slot] = last_load;
      slot = (slot + 1) % WindowLen;
      if (seen < WindowLen) seen++;
      want = '0;
      if (seen == WindowLen) begin
        sum = 0;
        foreach (ring[i]) sum += ring[i];
        want.load_percent = LoadW'(sum / WindowLen);
        want.window_full  = 1'b1;
      end
      expected_q.push_back(want);
    endfunction

    function void check_result(clma_out_t got);
      clma_out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("unexpected result: load_percent=%0d window_full=%0b",
                   got.load_percent, got.window_full);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.load_percent !== want.load_percent || got.window_full !== want.window_full) begin
        errors++;
        if (errors <= MaxReports)
          $display({"mismatch on result %0d: load_percent exp %0d got %0d, ",
                    "window_full exp %0b got %0b"},
                   checked, want.load_percent, got.load_percent,
                   want.window_full, got.window_full);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  clma_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  clma_out_t out_data_o;

  load_scoreboard sb = new();

  logic [CounterW-1:0] ctr [NumCounters];
  int unsigned idle_in_pct   = 0;
  int unsigned stall_pct     = 0;
  int unsigned items_sent    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned hold_left     = 0;
  bit          long_hold_req = 1'b0;

  cpu_load_moving_average DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Both channels are observed here, along with the no-progress watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_sample(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("timeout: no transaction for %0d cycles", QuietLimit);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // Output side: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (long_hold_req) begin
      hold_left     = HoldCycles;
      long_hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [CounterW-1:0] rand_counter();
    return CounterW'({$urandom, $urandom});
  endfunction

  function automatic clma_in_t random_sample();
    logic [575:0] raw;
    for (int w = 0; w < 576; w += 32) raw[w +: 32] = $urandom;
    return clma_in_t'(raw[$bits(clma_in_t)-1:0]);
  endfunction

  task automatic send_item(clma_in_t s);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < idle_in_pct) gap = $urandom_range(1, 90);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_counters(bit ok);
    clma_in_t s;
    s.sample_ok    = ok;
    s.user_time    = ctr[0];
    s.nice_time    = ctr[1];
    s.system_time  = ctr[2];
    s.idle_time    = ctr[IdleIndex];
    s.iowait_time  = ctr[4];
    s.irq_time     = ctr[5];
    s.softirq_time = ctr[6];
    s.steal_time   = ctr[7];
    s.guest_time   = ctr[8];
    send_item(s);
  endtask

  task automatic send_invalid();
    clma_in_t s;
    s = random_sample();
    s.sample_ok = 1'b0;
    send_item(s);
  endtask

  // Monotonic counters from a random base, each with its own growth rate, so the
  // load ratio stays meaningful across the sequence.
  task automatic run_sequence(int unsigned len);
    int unsigned width [NumCounters];
    foreach (ctr[k]) begin
      ctr[k]   = rand_counter() >> $urandom_range(0, CounterW - 1);
      width[k] = $urandom_range(1, 40);
    end
    for (int n = 0; n < len; n++) begin
      foreach (ctr[k]) ctr[k] += rand_counter() >> (CounterW - width[k]);
      if ($urandom_range(9) == 0) send_invalid();
      else send_counters(1'b1);
    end
  endtask

  // Counter rollback, idle time moved to or from busy time, or busy growing past total.
  task automatic run_broken();
    logic [CounterW-1:0] amount;
    int unsigned         k;
    amount = CounterW'($urandom_range(0, 300));
    k      = $urandom_range(0, NumCounters - 2);
    if (k >= IdleIndex) k++;
    case ($urandom_range(2))
      0: ctr[$urandom_range(NumCounters - 1)] -= rand_counter() >> $urandom_range(0, 62);
      1: begin
        if ($urandom_range(1)) begin
          ctr[IdleIndex] -= amount;
          ctr[k]         += amount;
        end else begin
          ctr[IdleIndex] += amount;
          ctr[k]         -= amount;
        end
      end
      default: begin
        ctr[IdleIndex] -= amount;
        ctr[k]         += amount + CounterW'($urandom_range(1, 50));
      end
    endcase
    send_counters(1'b1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainTail) @(posedge clk_i);
  endtask

  initial begin
    bit          hold_done;
    int unsigned target;
    int unsigned pick;
    hold_done = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: zero and full-scale counters, then hand-built deltas.
    foreach (ctr[k]) ctr[k] = '0;
    send_counters(1'b1);
    foreach (ctr[k]) ctr[k] = '1;
    send_counters(1'b0);
    send_counters(1'b1);
    foreach (ctr[k]) ctr[k] = '0;
    send_counters(1'b1);
    ctr[0] = CounterW'(1000);
    ctr[IdleIndex] = CounterW'(1000);
    send_counters(1'b1);
    ctr[IdleIndex] -= CounterW'(7);
    ctr[0] += CounterW'(7);
    send_counters(1'b1);
    ctr[IdleIndex] -= CounterW'(300);
    ctr[0] += CounterW'(300);
    send_counters(1'b1);
    ctr[IdleIndex] += CounterW'(50);
    ctr[0] -= CounterW'(50);
    send_counters(1'b1);
    ctr[0] += CounterW'(10);
    ctr[IdleIndex] -= CounterW'(100);
    send_counters(1'b1);
    ctr[0] -= CounterW'(100);
    ctr[IdleIndex] -= CounterW'(100);
    send_counters(1'b1);
    ctr[IdleIndex] -= CounterW'(200);
    ctr[0] += CounterW'(300);
    send_counters(1'b1);
    ctr[0] += CounterW'(25);
    ctr[IdleIndex] += CounterW'(75);
    send_counters(1'b1);
    send_invalid();
    foreach (ctr[k]) ctr[k] += CounterW'((k == IdleIndex) ? 2 : 1);
    send_counters(1'b1);
    ctr[8] = '1;
    send_counters(1'b1);
    foreach (ctr[k]) ctr[k] = (k == IdleIndex) ? '0 : '1;
    send_counters(1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_in_pct = 0;
          stall_pct   = 0;
        end
        1: begin
          idle_in_pct = 78;
          stall_pct   = 0;
        end
        2: begin
          idle_in_pct = 0;
          stall_pct   = 78;
        end
        default: begin
          idle_in_pct = 16;
          stall_pct   = 16;
        end
      endcase
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          run_sequence($urandom_range(6, 20));
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 5)) send_item(random_sample());
        end else begin
          run_broken();
        end
        // Stall the output for a long stretch while the input keeps offering samples.
        if (p == 0 && !hold_done && items_sent + 200 >= target) begin
          long_hold_req = 1'b1;
          hold_done     = 1'b1;
        end
      end
      drain();
    end

    $display("Ran %0d samples (%0d invalid, %0d with unchanged total, %0d at full load)",
             items_sent, sb.invalid_cnt, sb.flat_cnt, sb.full_load_cnt);
    $display({"and checked %0d results across four handshake pacing phases ",
              "and a long output stall."}, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
